### sv/omni_wheel_odometry_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by owo_back in the odometry RTL.
// ---------------------------------------------------------------------------
`ifndef OMNI_WHEEL_ODOMETRY_DEFINES_SVH
`define OMNI_WHEEL_ODOMETRY_DEFINES_SVH

// Check that a condition implies a result in the same cycle.
`define OWO_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that a condition implies a result in the next cycle.
`define OWO_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### sv/owo_pkg.sv
// ---------------------------------------------------------------------------
// owo_pkg
// Types and constants for the three-wheel omni odometry block.
// ---------------------------------------------------------------------------
package owo_pkg;
	localparam int CordicSteps = 14;
	localparam int GainQ24 = 10188014;
	localparam logic [19:0] InvSqrt3Q20 = 20'd605396;
	localparam logic [2:0] ModeStep = 3'd0;
	localparam logic [2:0] ModeSetAll = 3'd1;
	localparam logic [2:0] ModeSetX = 3'd2;
	localparam logic [2:0] ModeSetY = 3'd3;
	localparam logic [2:0] ModeSetHead = 3'd4;
	localparam logic [1:0] RegCpr = 2'd0;
	localparam logic [1:0] RegLpc = 2'd1;
	localparam logic [1:0] RegTpl = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic signed [47:0] t1;
		logic signed [47:0] t2;
		logic signed [47:0] t3;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic [15:0] new_heading;
	} req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DIFF, S_DXMUL, S_CLAMP, S_FOLD, S_CORDIC,
		S_MUL1, S_MUL2, S_SUM, S_ADD, S_OUT
	} back_state_t;

	function automatic logic signed [15:0] atan_units(input logic [3:0] i);
		case (i)
			4'd0: atan_units = 16'sd8192;
			4'd1: atan_units = 16'sd4836;
			4'd2: atan_units = 16'sd2555;
			4'd3: atan_units = 16'sd1297;
			4'd4: atan_units = 16'sd651;
			4'd5: atan_units = 16'sd326;
			4'd6: atan_units = 16'sd163;
			4'd7: atan_units = 16'sd81;
			4'd8: atan_units = 16'sd41;
			4'd9: atan_units = 16'sd20;
			4'd10: atan_units = 16'sd10;
			4'd11: atan_units = 16'sd5;
			4'd12: atan_units = 16'sd3;
			4'd13: atan_units = 16'sd1;
			default: atan_units = 16'sd0;
		endcase
	endfunction
endpackage

### sv/owo_front.sv
// ---------------------------------------------------------------------------
// owo_front
// Accepts requests, wraps step wheel deltas and scales them to wheel travel,
// one wheel per cycle through a shared multiplier, then queues the request.
// ---------------------------------------------------------------------------
module owo_front import owo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         mode,
	input  logic signed [15:0] wheel1_delta,
	input  logic signed [15:0] wheel2_delta,
	input  logic signed [15:0] wheel3_delta,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [15:0] new_heading,
	input  logic [15:0]        cpr,
	input  logic [31:0]        lpc,
	output logic               q_valid,
	output req_t               q_data,
	input  logic               q_take
);
	logic        busy_q;
	logic [1:0]  wsel_q;
	req_t        cur_q;
	logic signed [15:0] d_q [3];
	req_t        fifo_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic signed [16:0] d, dw, half;
	logic signed [49:0] prod;
	logic signed [47:0] tr;
	logic        done;

	assign full = busy_q;
	assign half = $signed({2'b0, cpr[15:1]});
	assign d = {d_q[wsel_q][15], d_q[wsel_q]};
	always_comb begin
		dw = d;
		if (d > half) dw = d - $signed({1'b0, cpr});
		else if (d < -half) dw = d + $signed({1'b0, cpr});
	end
	assign prod = dw * $signed({1'b0, lpc});
	assign tr = 48'(prod >>> 8);
	assign done = busy_q && (wsel_q == 2'd3) && (cnt_q != 2'd2);
	assign q_valid = cnt_q != 2'd0;
	assign q_data = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wsel_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !busy_q) begin
				busy_q <= 1'b1;
				wsel_q <= (mode == ModeStep) ? 2'd0 : 2'd3;
			end else if (busy_q && wsel_q != 2'd3) begin
				wsel_q <= wsel_q + 2'd1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, done} - {1'b0, q_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !busy_q) begin
			cur_q.mode <= mode;
			cur_q.new_x <= new_x;
			cur_q.new_y <= new_y;
			cur_q.new_heading <= new_heading;
			cur_q.t1 <= '0;
			cur_q.t2 <= '0;
			cur_q.t3 <= '0;
			d_q[0] <= wheel1_delta;
			d_q[1] <= wheel2_delta;
			d_q[2] <= wheel3_delta;
		end else if (busy_q) begin
			case (wsel_q)
				2'd0: cur_q.t1 <= tr;
				2'd1: cur_q.t2 <= tr;
				2'd2: cur_q.t3 <= tr;
				default: ;
			endcase
		end
		if (done) fifo_q[wr_q] <= cur_q;
	end
endmodule

### sv/owo_back.sv
// ---------------------------------------------------------------------------
// owo_back
// Carries out one queued request (step: body step, CORDIC on the heading,
// rotation, saturating sum; load: set fields), then hands the position on.
// ---------------------------------------------------------------------------
`include "omni_wheel_odometry_defines.svh"
module owo_back import owo_pkg::*; #(
	parameter int TRIG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  req_t               q_data,
	output logic               q_take,
	input  logic [31:0]        tpl,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading
);
	localparam int TW = TRIG_BITS + 3;
	localparam int GainT = (GainQ24 + ((1 << (24 - TRIG_BITS)) >> 1)) >> (24 - TRIG_BITS);
	localparam logic signed [38:0] Lim = 39'sd137438953472;

	back_state_t st_q, st_d;
	req_t        r_q;
	logic signed [31:0] x_q, y_q;
	logic [15:0] h_q;
	logic signed [48:0] a_q, b_q;
	logic signed [69:0] m_q;
	logic signed [38:0] dx_q, dy_q;
	logic signed [TW-1:0] cx_q, cy_q;
	logic signed [16:0] z_q;
	logic        flip_q;
	logic [3:0]  it_q;
	logic signed [TW+38:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [TW+39:0] rx_q, ry_q;
	logic [15:0] turn_q;
	logic [55:0] tlo_q;
	logic signed [24:0] thi_q;
	logic        ov_q;
	logic signed [31:0] ox_q, oy_q;
	logic [15:0] oh_q;
	logic signed [TW-1:0] shx, shy;
	logic [15:0] fu;
	logic signed [48:0] tsum;
	logic signed [57:0] thp;
	logic [55:0] tfull;
	logic signed [32:0] sx, sy;

	assign shx = cx_q >>> it_q;
	assign shy = cy_q >>> it_q;
	assign fu = h_q ^ 16'h8000;
	assign tsum = -(r_q.t1 + r_q.t2 + r_q.t3);
	assign thp = thi_q * $signed({1'b0, tpl});
	assign tfull = tlo_q + {thp[31:0], 24'b0};

	function automatic logic signed [32:0] sat(input logic signed [31:0] a,
		input logic signed [TW+39:0] b);
		logic signed [TW+40:0] s;
		s = (TW+41)'(a) + (TW+41)'(b);
		if (s > (TW+41)'(32'sh7fffffff)) sat = 33'sh07fffffff;
		else if (s < -(TW+41)'(33'sh080000000)) sat = -33'sh080000000;
		else sat = 33'(s);
	endfunction
	assign sx = sat(x_q, rx_q);
	assign sy = sat(y_q, ry_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (q_valid && !ov_q) st_d = (q_data.mode == ModeStep) ? S_DIFF : S_OUT;
			S_DIFF: st_d = S_DXMUL;
			S_DXMUL: st_d = S_CLAMP;
			S_CLAMP: st_d = S_FOLD;
			S_FOLD: st_d = S_CORDIC;
			S_CORDIC: if (it_q == 4'(CordicSteps - 1)) st_d = S_MUL1;
			S_MUL1: st_d = S_MUL2;
			S_MUL2: st_d = S_SUM;
			S_SUM: st_d = S_ADD;
			S_ADD: st_d = S_OUT;
			S_OUT: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb q_take = (st_q == S_IDLE) && q_valid && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			x_q <= '0;
			y_q <= '0;
			h_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_ADD) begin
				x_q <= sx[31:0];
				y_q <= sy[31:0];
				h_q <= h_q + turn_q;
			end
			if (st_q == S_OUT) begin
				if (r_q.mode == ModeSetAll || r_q.mode == ModeSetX) x_q <= r_q.new_x;
				if (r_q.mode == ModeSetAll || r_q.mode == ModeSetY) y_q <= r_q.new_y;
				if (r_q.mode == ModeSetAll || r_q.mode == ModeSetHead) h_q <= r_q.new_heading;
				ov_q <= 1'b1;
			end else if (pop && ov_q) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) r_q <= q_data;
		case (st_q)
			S_DIFF: begin
				a_q <= 49'(r_q.t3) - 49'(r_q.t2);
				b_q <= 49'(r_q.t1) - 49'(r_q.t2) - 49'(r_q.t3);
				tlo_q <= tsum[23:0] * tpl;
				thi_q <= tsum[48:24];
			end
			S_DXMUL: begin
				m_q <= a_q * $signed({1'b0, InvSqrt3Q20});
				turn_q <= tfull[55:40];
			end
			S_CLAMP: begin
				if ((m_q >>> 20) > 70'(Lim)) dx_q <= Lim;
				else if ((m_q >>> 20) < -70'(Lim)) dx_q <= -Lim;
				else dx_q <= 39'(m_q >>> 20);
				if ((b_q >>> 1) > 49'(Lim)) dy_q <= Lim;
				else if ((b_q >>> 1) < -49'(Lim)) dy_q <= -Lim;
				else dy_q <= 39'(b_q >>> 1);
			end
			S_FOLD: begin
				flip_q <= ((h_q + 16'h4000) >= 16'h8000);
				z_q <= ((h_q + 16'h4000) >= 16'h8000) ? 17'($signed(fu))
					: 17'($signed(h_q));
				cx_q <= TW'(GainT);
				cy_q <= '0;
				it_q <= '0;
			end
			S_CORDIC: begin
				if (!z_q[16]) begin
					cx_q <= cx_q - shy;
					cy_q <= cy_q + shx;
					z_q <= z_q - 17'(atan_units(it_q));
				end else begin
					cx_q <= cx_q + shy;
					cy_q <= cy_q - shx;
					z_q <= z_q + 17'(atan_units(it_q));
				end
				it_q <= it_q + 4'd1;
			end
			S_MUL1: begin
				if (flip_q) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
			end
			S_MUL2: begin
				p1_q <= dx_q * cx_q;
				p2_q <= dy_q * cy_q;
				p3_q <= dx_q * cy_q;
				p4_q <= dy_q * cx_q;
			end
			S_SUM: begin
				rx_q <= ((TW+40)'(p1_q) - (TW+40)'(p2_q)) >>> (TRIG_BITS + 8);
				ry_q <= ((TW+40)'(p3_q) + (TW+40)'(p4_q)) >>> (TRIG_BITS + 8);
			end
			default: ;
		endcase
		if (st_q == S_OUT) begin
			ox_q <= (r_q.mode == ModeSetAll || r_q.mode == ModeSetX) ? r_q.new_x : x_q;
			oy_q <= (r_q.mode == ModeSetAll || r_q.mode == ModeSetY) ? r_q.new_y : y_q;
			oh_q <= (r_q.mode == ModeSetAll || r_q.mode == ModeSetHead) ? r_q.new_heading
				: h_q;
		end
	end

	assign empty = !ov_q;
	assign pos_x = ox_q;
	assign pos_y = oy_q;
	assign heading = oh_q;

	`OWO_ASSERT_IMP(a_take_idle, clk, arst_n, q_take, st_q == S_IDLE, "take outside idle")
	`OWO_ASSERT_IMP(a_no_take_full, clk, arst_n, ov_q, !q_take, "take while result held")
	`OWO_ASSERT_NEXT(a_out_valid, clk, arst_n, st_q == S_OUT, ov_q, "result not presented")
endmodule

### sv/omni_wheel_odometry.sv
// ---------------------------------------------------------------------------
// omni_wheel_odometry
// Three-wheel omni base odometry: wheel travel front end, queue, and a
// step engine that rotates the body step by the heading and accumulates.
// ---------------------------------------------------------------------------
// channel   handshake       payload
// input     push / full     mode, wheel deltas, new_x, new_y, new_heading
// result    empty / pop     pos_x, pos_y, heading
// config    cfg_we          cfg_index, cfg_data
// In the front, a step request gets one wheel multiply per cycle; it then
// waits in the queue and runs the back with its 14-step CORDIC loop. A load
// request skips the multiplies and the CORDIC. The two-entry queue lets the
// front take the next request while the back works; the back takes no new
// request while a result waits. Reset clears position and heading; a result
// waits on the outputs until popped.
// ---------------------------------------------------------------------------
module omni_wheel_odometry import owo_pkg::*; #(
	parameter int TRIG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         mode,
	input  logic signed [15:0] wheel1_delta,
	input  logic signed [15:0] wheel2_delta,
	input  logic signed [15:0] wheel3_delta,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [15:0] new_heading,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	logic [15:0] cpr_q;
	logic [31:0] lpc_q, tpl_q;
	logic        q_valid, q_take;
	req_t        q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= 16'd4096;
			lpc_q <= '0;
			tpl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegCpr: cpr_q <= cfg_data[15:0];
				RegLpc: lpc_q <= cfg_data;
				RegTpl: tpl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	owo_front u_front (
		.clk, .arst_n, .push, .full, .mode, .wheel1_delta, .wheel2_delta,
		.wheel3_delta, .new_x, .new_y, .new_heading,
		.cpr(cpr_q), .lpc(lpc_q), .q_valid, .q_data, .q_take
	);

	owo_back #(.TRIG_BITS(TRIG_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_take, .tpl(tpl_q),
		.empty, .pop, .pos_x, .pos_y, .heading
	);
endmodule
